### rtl/assert_macros.svh
// assertion macros used by the retrying request queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds every cycle out of reset
`define RRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds the cycle after the antecedent
`define RRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rrq_pkg.sv
// types and codes of the retrying request queue
package rrq_pkg;

    localparam logic [2:0] ACT_SUBMIT     = 3'd0;
    localparam logic [2:0] ACT_GET_JOB    = 3'd1;
    localparam logic [2:0] ACT_COMPLETE   = 3'd2;
    localparam logic [2:0] ACT_CANCEL     = 3'd3;
    localparam logic [2:0] ACT_CANCEL_ALL = 3'd4;

    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_PERMANENT = 3'd3;
    localparam logic [2:0] ST_RETRY_LIM = 3'd4;

    localparam logic [1:0] ATT_SUCCESS   = 2'd0;
    localparam logic [1:0] ATT_PERMANENT = 2'd2;

    localparam logic [2:0] MAX_LEN      = 3'd4;
    localparam logic [7:0] ATT_SAT      = 8'd255;
    localparam logic [4:0] LIMIT_RESET  = 5'd16;

    typedef struct packed {
        logic [2:0]  action;
        logic        is_write;
        logic [15:0] device_id;
        logic [15:0] object_index;
        logic [7:0]  object_subindex;
        logic [2:0]  data_length;
        logic [31:0] write_data;
        logic [7:0]  max_attempts;
        logic        retry_enabled;
        logic [15:0] job_id;
        logic [1:0]  attempt_status;
        logic [31:0] attempt_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        ok_flag;
        logic [15:0] out_job_id;
        logic [2:0]  status_code;
        logic [31:0] out_data;
        logic        out_is_write;
        logic [15:0] out_device_id;
        logic [15:0] out_object_index;
        logic [7:0]  out_object_subindex;
        logic [2:0]  out_data_length;
        logic [4:0]  pending_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        is_write;
        logic [15:0] device_id;
        logic [15:0] object_index;
        logic [7:0]  object_subindex;
        logic [2:0]  data_length;
    } t_request;

    typedef struct packed {
        logic [7:0] attempts;
        logic       retry_enabled;
        logic [7:0] max_attempts;
    } t_retry;

endpackage

### rtl/rrq_if.sv
// valid/ready channel interfaces for requests, results and configuration
interface rrq_req_if;
    logic              valid;
    logic              ready;
    rrq_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrq_res_if;
    logic               valid;
    logic               ready;
    rrq_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrq_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] queue_limit;
    modport source (output valid, output queue_limit, input ready);
    modport sink (input valid, input queue_limit, output ready);
endinterface

### rtl/rrq_ram.sv
// generic simple dual-port ram with registered read
module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/retrying_request_queue.sv
// retrying request queue: sequencer around one queue ram
// one command at a time; submit and unknown actions answer from the dispatch
// state, complete adds a done result when the job ends; get job reads the head,
// then compacts through the ram, one entry a cycle; cancel scans one entry a
// cycle and then compacts; cancel all reads, then reports, each job in turn
// synchronous active-low reset empties the queue, limit 16, next id 1
`include "assert_macros.svh"

module retrying_request_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrq_cfg_if.sink     i_cfg,
    rrq_req_if.sink     i_req,
    rrq_res_if.source   o_res
);
    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (ID_WIDTH > 16) ? ID_WIDTH : 16;

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        rrq_pkg::t_request   req;
        logic [31:0]         payload;
        rrq_pkg::t_retry     rt;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_GET   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_EMIT2 = 9'b000010000,
        S_SHIFT = 9'b000100000,
        S_SHW   = 9'b001000000,
        S_CAR   = 9'b010000000,
        S_CAW   = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    rrq_pkg::t_in_item   r_cmd, n_cmd;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_end, n_end;
    logic                r_act_valid, n_act_valid;
    logic                r_act_cancel, n_act_cancel;
    t_entry              r_act, n_act;
    logic [ID_WIDTH-1:0] r_next_id, n_next_id;
    logic [4:0]          r_limit;
    rrq_pkg::t_out_item  r_res2, n_res2;
    logic                r_shift_after, n_shift_after;
    logic                r_ov;
    rrq_pkg::t_out_item  r_out;

    logic                emit;
    rrq_pkg::t_out_item  emit_val;
    logic                out_free;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    t_entry              ram_wdata, ram_rdata;
    logic [EW-1:0]       ram_rdata_raw;

    rrq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );
    assign ram_rdata = ram_rdata_raw;

    function automatic rrq_pkg::t_out_item mk_res(
        input logic [1:0]          kind,
        input logic                ok,
        input logic [15:0]         id,
        input logic [2:0]          st,
        input logic [31:0]         data,
        input rrq_pkg::t_request   req,
        input logic [CW-1:0]       cnt,
        input logic                act,
        input logic                lst
    );
        rrq_pkg::t_out_item r;
        r.result_kind         = kind;
        r.ok_flag             = ok;
        r.out_job_id          = id;
        r.status_code         = st;
        r.out_data            = data;
        r.out_is_write        = req.is_write;
        r.out_device_id       = req.device_id;
        r.out_object_index    = req.object_index;
        r.out_object_subindex = req.object_subindex;
        r.out_data_length     = req.data_length;
        r.pending_count       = 5'(6'(cnt) + 6'(act));
        r.last                = lst;
        return r;
    endfunction

    assign out_free    = !r_ov || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    logic [5:0]          pend_now;
    logic                act_match;
    logic                scan_match;
    logic [ID_WIDTH-1:0] id_inc;
    logic [2:0]          len_clamp;
    logic                retry_limit;
    logic [7:0]          att_inc;

    assign pend_now    = 6'(r_count) + 6'(r_act_valid);
    assign act_match   = r_act_valid && (CMPW'(r_act.id) == CMPW'(r_cmd.job_id));
    assign scan_match  = (CMPW'(ram_rdata.id) == CMPW'(r_cmd.job_id));
    assign id_inc      = r_next_id + ID_WIDTH'(1);
    assign len_clamp   = (r_cmd.data_length > rrq_pkg::MAX_LEN) ? rrq_pkg::MAX_LEN
                                                                : r_cmd.data_length;
    assign retry_limit = (r_act.rt.max_attempts != 8'd0) &&
                         (r_act.rt.attempts >= r_act.rt.max_attempts);
    assign att_inc     = (ram_rdata.rt.attempts == rrq_pkg::ATT_SAT) ? rrq_pkg::ATT_SAT
                                                                     : ram_rdata.rt.attempts + 8'd1;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_count       = r_count;
        n_idx         = r_idx;
        n_end         = r_end;
        n_act_valid   = r_act_valid;
        n_act_cancel  = r_act_cancel;
        n_act         = r_act;
        n_next_id     = r_next_id;
        n_res2        = r_res2;
        n_shift_after = r_shift_after;
        emit          = 1'b0;
        emit_val      = '0;
        ram_we        = 1'b0;
        ram_waddr     = r_count[AW-1:0];
        ram_wdata     = r_act;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.data;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_cmd.action)
                    rrq_pkg::ACT_SUBMIT: begin
                        if (out_free) begin
                            n_state = S_IDLE;
                            emit    = 1'b1;
                            if (pend_now >= 6'(r_limit) || r_count >= CW'(QUEUE_DEPTH)) begin
                                emit_val = mk_res(rrq_pkg::KIND_ACK, 1'b0, 16'd0,
                                                  rrq_pkg::ST_FULL, 32'd0, '0,
                                                  r_count, r_act_valid, 1'b1);
                            end else begin
                                ram_we                     = 1'b1;
                                ram_wdata.id               = r_next_id;
                                ram_wdata.req.is_write     = r_cmd.is_write;
                                ram_wdata.req.device_id    = r_cmd.device_id;
                                ram_wdata.req.object_index = r_cmd.object_index;
                                ram_wdata.req.object_subindex = r_cmd.object_subindex;
                                ram_wdata.req.data_length  = len_clamp;
                                ram_wdata.payload          = r_cmd.write_data;
                                ram_wdata.rt.attempts      = 8'd0;
                                ram_wdata.rt.retry_enabled = r_cmd.retry_enabled;
                                ram_wdata.rt.max_attempts  = r_cmd.max_attempts;
                                n_count   = r_count + CW'(1);
                                n_next_id = (id_inc == '0) ? ID_WIDTH'(1) : id_inc;
                                emit_val  = mk_res(rrq_pkg::KIND_ACK, 1'b1, 16'(r_next_id),
                                                   rrq_pkg::ST_OK, 32'd0, '0,
                                                   n_count, r_act_valid, 1'b1);
                            end
                        end
                    end
                    rrq_pkg::ACT_GET_JOB: begin
                        if (r_act_valid || r_count == '0) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                emit_val = mk_res(rrq_pkg::KIND_DISPATCH, 1'b0, 16'd0,
                                                  rrq_pkg::ST_OK, 32'd0, '0,
                                                  r_count, r_act_valid, 1'b1);
                                n_state  = S_IDLE;
                            end
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_state   = S_GET;
                        end
                    end
                    rrq_pkg::ACT_COMPLETE: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (!act_match) begin
                                emit_val = mk_res(rrq_pkg::KIND_ACK, 1'b0, r_cmd.job_id,
                                                  rrq_pkg::ST_OK, 32'd0, '0,
                                                  r_count, r_act_valid, 1'b1);
                                n_state  = S_IDLE;
                            end else begin
                                n_act_valid   = 1'b0;
                                n_act_cancel  = 1'b0;
                                n_shift_after = 1'b0;
                                n_state       = S_EMIT2;
                                if (r_act_cancel) begin
                                    n_res2 = mk_res(rrq_pkg::KIND_DONE, 1'b1, 16'(r_act.id),
                                                    rrq_pkg::ST_CANCELLED, 32'd0, '0,
                                                    r_count, 1'b0, 1'b1);
                                end else if (r_cmd.attempt_status == rrq_pkg::ATT_SUCCESS) begin
                                    n_res2 = mk_res(rrq_pkg::KIND_DONE, 1'b1, 16'(r_act.id),
                                                    rrq_pkg::ST_OK, r_cmd.attempt_data, '0,
                                                    r_count, 1'b0, 1'b1);
                                end else if (r_cmd.attempt_status == rrq_pkg::ATT_PERMANENT) begin
                                    n_res2 = mk_res(rrq_pkg::KIND_DONE, 1'b1, 16'(r_act.id),
                                                    rrq_pkg::ST_PERMANENT, 32'd0, '0,
                                                    r_count, 1'b0, 1'b1);
                                end else if (r_act.rt.retry_enabled && !retry_limit) begin
                                    if (r_count < CW'(QUEUE_DEPTH)) begin
                                        ram_we  = 1'b1;
                                        n_count = r_count + CW'(1);
                                    end
                                    n_state = S_IDLE;
                                end else begin
                                    n_res2 = mk_res(rrq_pkg::KIND_DONE, 1'b1, 16'(r_act.id),
                                                    rrq_pkg::ST_RETRY_LIM, 32'd0, '0,
                                                    r_count, 1'b0, 1'b1);
                                end
                                emit_val = mk_res(rrq_pkg::KIND_ACK, 1'b1, 16'(r_act.id),
                                                  rrq_pkg::ST_OK, 32'd0, '0,
                                                  n_count, 1'b0, n_state == S_IDLE);
                            end
                        end
                    end
                    rrq_pkg::ACT_CANCEL: begin
                        if (r_count != '0) begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end else if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (act_match) begin
                                n_act_cancel = 1'b1;
                            end
                            emit_val = mk_res(rrq_pkg::KIND_ACK, act_match, r_cmd.job_id,
                                              rrq_pkg::ST_OK, 32'd0, '0,
                                              r_count, r_act_valid, 1'b1);
                        end
                    end
                    rrq_pkg::ACT_CANCEL_ALL: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_count = '0;
                            n_end   = r_count;
                            n_idx   = '0;
                            if (r_act_valid) begin
                                n_act_cancel = 1'b1;
                            end
                            emit_val = mk_res(rrq_pkg::KIND_ACK, 1'b1, 16'd0,
                                              rrq_pkg::ST_OK, 32'd0, '0,
                                              '0, r_act_valid, r_count == '0);
                            n_state  = (r_count == '0) ? S_IDLE : S_CAR;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            emit_val = mk_res(rrq_pkg::KIND_ACK, 1'b0, 16'd0,
                                              rrq_pkg::ST_OK, 32'd0, '0,
                                              r_count, r_act_valid, 1'b1);
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_GET: begin
                if (out_free) begin
                    n_act             = ram_rdata;
                    n_act.rt.attempts = att_inc;
                    n_act_valid       = 1'b1;
                    n_act_cancel      = 1'b0;
                    n_count           = r_count - CW'(1);
                    n_end             = r_count - CW'(1);
                    n_idx             = '0;
                    emit              = 1'b1;
                    emit_val = mk_res(rrq_pkg::KIND_DISPATCH, 1'b1, 16'(ram_rdata.id),
                                      rrq_pkg::ST_OK,
                                      ram_rdata.req.is_write ? ram_rdata.payload : 32'd0,
                                      ram_rdata.req, n_count, 1'b1, 1'b1);
                    n_state  = S_SHIFT;
                end
            end
            S_SCAN: begin
                if (scan_match) begin
                    if (out_free) begin
                        n_count       = r_count - CW'(1);
                        n_end         = r_count - CW'(1);
                        n_shift_after = 1'b1;
                        emit          = 1'b1;
                        emit_val = mk_res(rrq_pkg::KIND_ACK, 1'b1, r_cmd.job_id,
                                          rrq_pkg::ST_OK, 32'd0, '0,
                                          n_count, r_act_valid, 1'b0);
                        n_res2   = mk_res(rrq_pkg::KIND_DONE, 1'b1, r_cmd.job_id,
                                          rrq_pkg::ST_CANCELLED, 32'd0, '0,
                                          n_count, r_act_valid, 1'b1);
                        n_state  = S_EMIT2;
                    end
                end else if (r_idx + CW'(1) < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + CW'(1));
                    n_idx     = r_idx + CW'(1);
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (act_match) begin
                        n_act_cancel = 1'b1;
                    end
                    emit_val = mk_res(rrq_pkg::KIND_ACK, act_match, r_cmd.job_id,
                                      rrq_pkg::ST_OK, 32'd0, '0,
                                      r_count, r_act_valid, 1'b1);
                end
            end
            S_EMIT2: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_val = r_res2;
                    n_state  = r_shift_after ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT: begin
                if (r_idx < r_end) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + CW'(1));
                    n_state   = S_SHW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHW: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = ram_rdata;
                if (r_idx + CW'(1) < r_end) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + CW'(2));
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CAR: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx[AW-1:0];
                n_state   = S_CAW;
            end
            S_CAW: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_val = mk_res(rrq_pkg::KIND_DONE, 1'b1, 16'(ram_rdata.id),
                                      rrq_pkg::ST_CANCELLED, 32'd0, '0,
                                      '0, r_act_valid, r_idx + CW'(1) == r_end);
                    if (r_idx + CW'(1) == r_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_CAR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_act_valid   <= 1'b0;
            r_act_cancel  <= 1'b0;
            r_next_id     <= ID_WIDTH'(1);
            r_limit       <= rrq_pkg::LIMIT_RESET;
            r_ov          <= 1'b0;
            r_idx         <= '0;
            r_end         <= '0;
            r_shift_after <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_act_valid   <= n_act_valid;
            r_act_cancel  <= n_act_cancel;
            r_next_id     <= n_next_id;
            r_idx         <= n_idx;
            r_end         <= n_end;
            r_shift_after <= n_shift_after;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.queue_limit;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_act  <= n_act;
        r_res2 <= n_res2;
        if (emit) begin
            r_out <= emit_val;
        end
    end

    `RRQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH),
        "queue count above depth")
    `RRQ_ASSERT(a_cancel_needs_active, i_clk, i_rst_n, !r_act_cancel || r_act_valid,
        "cancel mark without active job")
    `RRQ_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready,
        r_state == S_DISP, "accepted beat not dispatched")
    `RRQ_ASSERT(a_no_emit_over_full, i_clk, i_rst_n, !emit || out_free,
        "result overwrites a waiting beat")
endmodule
